// File: design/gmwf_pkg.sv
package gmwf_pkg;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_STEP    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic       en;
    logic [3:0] row;
    logic [3:0] col;
    logic       wall;
  } wr_req_t;

  typedef struct packed {
    logic [3:0] start_row;
    logic [3:0] start_col;
    logic [1:0] start_heading;
    logic [3:0] goal_row;
    logic [3:0] goal_col;
  } cfg_t;

  typedef struct packed {
    logic [3:0] pos_row;
    logic [3:0] pos_col;
    logic [1:0] heading;
    logic       heading_set;
    logic       at_goal;
    logic       stuck;
  } result_t;

  function automatic logic [1:0] turn_right(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      DIR_UP:    r = DIR_RIGHT;
      DIR_DOWN:  r = DIR_LEFT;
      DIR_LEFT:  r = DIR_UP;
      DIR_RIGHT: r = DIR_DOWN;
      default:   r = DIR_UP;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] turn_left(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      DIR_UP:    r = DIR_LEFT;
      DIR_DOWN:  r = DIR_RIGHT;
      DIR_LEFT:  r = DIR_DOWN;
      DIR_RIGHT: r = DIR_UP;
      default:   r = DIR_UP;
    endcase
    return r;
  endfunction

endpackage

// File: design/gmwf_maze_mem.sv
module gmwf_maze_mem #(
  parameter int GRID_SIZE = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(GRID_SIZE)-1:0] rd_row_i,
  input  gmwf_pkg::wr_req_t          wr_i,
  output logic [GRID_SIZE-1:0]       up_row_o,
  output logic [GRID_SIZE-1:0]       cur_row_o,
  output logic [GRID_SIZE-1:0]       dn_row_o
);

  localparam int PW = $clog2(GRID_SIZE);
  localparam int HD = (GRID_SIZE + 1) / 2;
  localparam int AW = (HD > 1) ? $clog2(HD) : 1;

  // even rows in one bank, odd rows in the other
  logic [GRID_SIZE-1:0] even_mem [HD];
  logic [GRID_SIZE-1:0] odd_mem  [HD];

  logic [GRID_SIZE-1:0] even_a_q, even_b_q, odd_a_q, odd_b_q;
  logic [GRID_SIZE-1:0] row_valid_q;
  logic                 par_q, up_v_q, cur_v_q, dn_v_q;
  logic [PW-1:0]        rd_row_q;
  gmwf_pkg::wr_req_t    wr_q;

  logic [AW-1:0]        cur_a, up_a, dn_a;
  logic [AW-1:0]        even_a_addr, odd_a_addr;
  logic [AW-1:0]        wa;
  logic [PW-1:0]        wc, wrow, pc;
  logic [GRID_SIZE-1:0] wfill;

  always_comb begin
    int nh;
    int ui;
    int di;
    nh = int'(rd_row_i) >> 1;
    ui = rd_row_i[0] ? nh : nh - 1;
    di = rd_row_i[0] ? nh + 1 : nh;
    cur_a = AW'(nh);
    up_a  = (ui < 0) ? '0 : AW'(ui);
    dn_a  = (di >= HD) ? '0 : AW'(di);
  end

  assign even_a_addr = rd_row_i[0] ? up_a : cur_a;
  assign odd_a_addr  = rd_row_i[0] ? cur_a : up_a;

  assign wa    = AW'(wr_i.row >> 1);
  assign wc    = PW'(wr_i.col);
  assign wrow  = PW'(wr_i.row);
  assign wfill = GRID_SIZE'(wr_i.wall) << wc;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.row[0]) begin
      if (row_valid_q[wrow]) begin
        even_mem[wa][wc] <= wr_i.wall;
      end else begin
        even_mem[wa] <= wfill;
      end
    end
    even_a_q <= even_mem[even_a_addr];
    even_b_q <= even_mem[dn_a];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.row[0]) begin
      if (row_valid_q[wrow]) begin
        odd_mem[wa][wc] <= wr_i.wall;
      end else begin
        odd_mem[wa] <= wfill;
      end
    end
    odd_a_q <= odd_mem[odd_a_addr];
    odd_b_q <= odd_mem[dn_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      par_q       <= 1'b0;
      up_v_q      <= 1'b0;
      cur_v_q     <= 1'b0;
      dn_v_q      <= 1'b0;
      rd_row_q    <= '0;
      wr_q        <= '0;
    end else begin
      if (wr_i.en) begin
        row_valid_q[wrow] <= 1'b1;
      end
      par_q    <= rd_row_i[0];
      rd_row_q <= rd_row_i;
      wr_q     <= wr_i;
      up_v_q   <= (rd_row_i != '0) && row_valid_q[rd_row_i - PW'(1)];
      cur_v_q  <= row_valid_q[rd_row_i];
      dn_v_q   <= (int'(rd_row_i) < GRID_SIZE - 1) && row_valid_q[rd_row_i + PW'(1)];
    end
  end

  assign pc = PW'(wr_q.col);

  // read data predates a write in the same cycle: patch that bit
  always_comb begin
    up_row_o  = up_v_q  ? (par_q ? even_a_q : odd_a_q)  : '0;
    cur_row_o = cur_v_q ? (par_q ? odd_a_q  : even_a_q) : '0;
    dn_row_o  = dn_v_q  ? (par_q ? even_b_q : odd_b_q)  : '0;
    if (wr_q.en) begin
      if (int'(wr_q.row) + 1 == int'(rd_row_q)) up_row_o[pc] = wr_q.wall;
      if (int'(wr_q.row) == int'(rd_row_q)) cur_row_o[pc] = wr_q.wall;
      if (int'(wr_q.row) == int'(rd_row_q) + 1) dn_row_o[pc] = wr_q.wall;
    end
  end

endmodule

// File: design/gmwf_step.sv
module gmwf_step #(
  parameter int GRID_SIZE = 16
) (
  input  logic [1:0]                   req_i,
  input  logic [$clog2(GRID_SIZE)-1:0] pos_row_i,
  input  logic [$clog2(GRID_SIZE)-1:0] pos_col_i,
  input  logic [1:0]                   heading_i,
  input  logic                         hvalid_i,
  input  gmwf_pkg::cfg_t               cfg_i,
  input  logic [GRID_SIZE-1:0]         up_row_i,
  input  logic [GRID_SIZE-1:0]         cur_row_i,
  input  logic [GRID_SIZE-1:0]         dn_row_i,
  output logic [$clog2(GRID_SIZE)-1:0] nxt_row_o,
  output logic [$clog2(GRID_SIZE)-1:0] nxt_col_o,
  output logic [1:0]                   nxt_heading_o,
  output logic                         nxt_hvalid_o,
  output gmwf_pkg::result_t            res_o
);

  localparam int PW = $clog2(GRID_SIZE);

  logic [3:0]    on_map, open_d;
  logic [PW-1:0] nb_row [4];
  logic [PW-1:0] nb_col [4];
  logic [PW-1:0] col_m1, col_p1, row_m1, row_p1;
  logic          stuck;

  assign col_m1 = pos_col_i - PW'(1);
  assign col_p1 = pos_col_i + PW'(1);
  assign row_m1 = pos_row_i - PW'(1);
  assign row_p1 = pos_row_i + PW'(1);

  assign on_map[gmwf_pkg::DIR_UP]    = pos_row_i != '0;
  assign on_map[gmwf_pkg::DIR_DOWN]  = int'(pos_row_i) < GRID_SIZE - 1;
  assign on_map[gmwf_pkg::DIR_LEFT]  = pos_col_i != '0;
  assign on_map[gmwf_pkg::DIR_RIGHT] = int'(pos_col_i) < GRID_SIZE - 1;

  assign open_d[gmwf_pkg::DIR_UP]    = on_map[gmwf_pkg::DIR_UP]    && !up_row_i[pos_col_i];
  assign open_d[gmwf_pkg::DIR_DOWN]  = on_map[gmwf_pkg::DIR_DOWN]  && !dn_row_i[pos_col_i];
  assign open_d[gmwf_pkg::DIR_LEFT]  = on_map[gmwf_pkg::DIR_LEFT]  && !cur_row_i[col_m1];
  assign open_d[gmwf_pkg::DIR_RIGHT] = on_map[gmwf_pkg::DIR_RIGHT] && !cur_row_i[col_p1];

  assign nb_row[gmwf_pkg::DIR_UP]    = row_m1;
  assign nb_row[gmwf_pkg::DIR_DOWN]  = row_p1;
  assign nb_row[gmwf_pkg::DIR_LEFT]  = pos_row_i;
  assign nb_row[gmwf_pkg::DIR_RIGHT] = pos_row_i;
  assign nb_col[gmwf_pkg::DIR_UP]    = pos_col_i;
  assign nb_col[gmwf_pkg::DIR_DOWN]  = pos_col_i;
  assign nb_col[gmwf_pkg::DIR_LEFT]  = col_m1;
  assign nb_col[gmwf_pkg::DIR_RIGHT] = col_p1;

  always_comb begin
    logic       found;
    logic [1:0] th, h, rh, lh, bh;
    nxt_row_o     = pos_row_i;
    nxt_col_o     = pos_col_i;
    nxt_heading_o = heading_i;
    nxt_hvalid_o  = hvalid_i;
    stuck         = 1'b0;
    found         = 1'b0;
    th            = '0;
    h             = heading_i;
    rh            = gmwf_pkg::turn_right(h);
    lh            = gmwf_pkg::turn_left(h);
    bh            = h ^ 2'd1;
    case (req_i)
      gmwf_pkg::REQ_STEP: begin
        if (hvalid_i) begin
          if (!open_d[rh] && open_d[h]) begin
            nxt_row_o = nb_row[h];
            nxt_col_o = nb_col[h];
          end else if (open_d[rh] && on_map[h]) begin
            nxt_row_o     = nb_row[rh];
            nxt_col_o     = nb_col[rh];
            nxt_heading_o = rh;
          end else if (open_d[lh]) begin
            nxt_row_o     = nb_row[lh];
            nxt_col_o     = nb_col[lh];
            nxt_heading_o = lh;
          end else begin
            if (on_map[bh]) begin
              nxt_row_o = nb_row[bh];
              nxt_col_o = nb_col[bh];
            end
            nxt_heading_o = bh;
          end
        end else begin
          for (int k = 0; k < 4; k++) begin
            th = cfg_i.start_heading + 2'(k);
            if (!found && open_d[th]) begin
              found         = 1'b1;
              nxt_row_o     = nb_row[th];
              nxt_col_o     = nb_col[th];
              nxt_heading_o = th;
              nxt_hvalid_o  = 1'b1;
            end
          end
          stuck = !found;
        end
      end
      gmwf_pkg::REQ_RESTART: begin
        nxt_row_o     = (int'(cfg_i.start_row) >= GRID_SIZE) ? PW'(GRID_SIZE - 1)
                                                             : PW'(cfg_i.start_row);
        nxt_col_o     = (int'(cfg_i.start_col) >= GRID_SIZE) ? PW'(GRID_SIZE - 1)
                                                             : PW'(cfg_i.start_col);
        nxt_heading_o = gmwf_pkg::DIR_UP;
        nxt_hvalid_o  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign res_o.pos_row     = 4'(nxt_row_o);
  assign res_o.pos_col     = 4'(nxt_col_o);
  assign res_o.heading     = nxt_heading_o;
  assign res_o.heading_set = nxt_hvalid_o;
  assign res_o.at_goal     = (int'(nxt_row_o) == int'(cfg_i.goal_row)) &&
                             (int'(nxt_col_o) == int'(cfg_i.goal_col));
  assign res_o.stuck       = stuck;

endmodule

// File: design/gmwf_out_buf.sv
module gmwf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gmwf_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output gmwf_pkg::result_t data_o
);

  gmwf_pkg::result_t ent_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = ent_q[rd_ptr_q];
  assign pop     = valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("result buffer count did not grow on push");

endmodule

// File: design/grid_maze_wall_follower.sv
// Right-hand wall follower on a grid maze.
// Throughput: one transaction per cycle while the result buffer has room; the
// maze banks are read each cycle for the rows around the next position, so steps
// issue back to back. Output: the result is registered and offered in order.
// Reset: registers and robot state clear; per-row valid bits make the whole maze
// read as open at once, with no clearing pass.
module grid_maze_wall_follower #(
  parameter int GRID_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  cell_row_i,
  input  logic [3:0]  cell_col_i,
  input  logic        cell_wall_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  pos_row_o,
  output logic [3:0]  pos_col_o,
  output logic [1:0]  heading_out_o,
  output logic        heading_set_o,
  output logic        at_goal_o,
  output logic        stuck_o
);

  localparam int PW = $clog2(GRID_SIZE);

  localparam logic [2:0] REG_START_ROW     = 3'd0;
  localparam logic [2:0] REG_START_COL     = 3'd1;
  localparam logic [2:0] REG_START_HEADING = 3'd2;
  localparam logic [2:0] REG_GOAL_ROW      = 3'd3;
  localparam logic [2:0] REG_GOAL_COL      = 3'd4;

  gmwf_pkg::cfg_t    cfg_q;
  logic [PW-1:0]     pos_row_q, pos_col_q;
  logic [1:0]        head_q;
  logic              hvalid_q;

  logic              acc;
  logic [PW-1:0]     nxt_row, nxt_col, rd_row;
  logic [1:0]        nxt_head;
  logic              nxt_hvalid;
  gmwf_pkg::result_t res, out_res;
  gmwf_pkg::wr_req_t wr;
  logic [GRID_SIZE-1:0] up_row, cur_row, dn_row;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_START_ROW:     cfg_q.start_row     <= pwdata[3:0];
        REG_START_COL:     cfg_q.start_col     <= pwdata[3:0];
        REG_START_HEADING: cfg_q.start_heading <= pwdata[1:0];
        REG_GOAL_ROW:      cfg_q.goal_row      <= pwdata[3:0];
        REG_GOAL_COL:      cfg_q.goal_col      <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START_ROW:     prdata = {28'd0, cfg_q.start_row};
      REG_START_COL:     prdata = {28'd0, cfg_q.start_col};
      REG_START_HEADING: prdata = {30'd0, cfg_q.start_heading};
      REG_GOAL_ROW:      prdata = {28'd0, cfg_q.goal_row};
      REG_GOAL_COL:      prdata = {28'd0, cfg_q.goal_col};
      default:           prdata = '0;
    endcase
  end

  assign acc = in_valid_i && in_ready_o;

  assign wr.en   = acc && (req_type_i == gmwf_pkg::REQ_WRITE) &&
                   (int'(cell_row_i) < GRID_SIZE) && (int'(cell_col_i) < GRID_SIZE);
  assign wr.row  = cell_row_i;
  assign wr.col  = cell_col_i;
  assign wr.wall = cell_wall_i;

  // fetch the neighborhood of wherever the robot will stand next cycle
  assign rd_row = acc ? nxt_row : pos_row_q;

  gmwf_maze_mem #(.GRID_SIZE(GRID_SIZE)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_row_i  (rd_row),
    .wr_i      (wr),
    .up_row_o  (up_row),
    .cur_row_o (cur_row),
    .dn_row_o  (dn_row)
  );

  gmwf_step #(.GRID_SIZE(GRID_SIZE)) u_step (
    .req_i         (req_type_i),
    .pos_row_i     (pos_row_q),
    .pos_col_i     (pos_col_q),
    .heading_i     (head_q),
    .hvalid_i      (hvalid_q),
    .cfg_i         (cfg_q),
    .up_row_i      (up_row),
    .cur_row_i     (cur_row),
    .dn_row_i      (dn_row),
    .nxt_row_o     (nxt_row),
    .nxt_col_o     (nxt_col),
    .nxt_heading_o (nxt_head),
    .nxt_hvalid_o  (nxt_hvalid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q <= '0;
      pos_col_q <= '0;
      head_q    <= gmwf_pkg::DIR_UP;
      hvalid_q  <= 1'b0;
    end else if (acc) begin
      pos_row_q <= nxt_row;
      pos_col_q <= nxt_col;
      head_q    <= nxt_head;
      hvalid_q  <= nxt_hvalid;
    end
  end

  gmwf_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (acc),
    .data_i      (res),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .data_o      (out_res)
  );

  assign pos_row_o     = out_res.pos_row;
  assign pos_col_o     = out_res.pos_col;
  assign heading_out_o = out_res.heading;
  assign heading_set_o = out_res.heading_set;
  assign at_goal_o     = out_res.at_goal;
  assign stuck_o       = out_res.stuck;

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_type_i == gmwf_pkg::REQ_RESTART |=> !hvalid_q)
    else $error("restart left a heading set");

  a_heading_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_type_i == gmwf_pkg::REQ_STEP && hvalid_q |=> hvalid_q)
    else $error("step lost the heading");

  a_write_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_type_i == gmwf_pkg::REQ_WRITE |=>
      pos_row_q == $past(pos_row_q) && pos_col_q == $past(pos_col_q))
    else $error("cell write moved the robot");

endmodule

// File: tb/grid_maze_wall_follower_checker.sv
package gmwf_tb_pkg;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    REG_START_ROW     = 3'd0,
    REG_START_COL     = 3'd1,
    REG_START_HEADING = 3'd2,
    REG_GOAL_ROW      = 3'd3,
    REG_GOAL_COL      = 3'd4
  } cfg_reg_e;

endpackage

module grid_maze_wall_follower_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  cell_row_i,
  input  logic [3:0]  cell_col_i,
  input  logic        cell_wall_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [3:0]  pos_row_o,
  input  logic [3:0]  pos_col_o,
  input  logic [1:0]  heading_out_o,
  input  logic        heading_set_o,
  input  logic        at_goal_o,
  input  logic        stuck_o,
  output int          mismatch_count_o,
  output int          pending_o
);

  import gmwf_pkg::*;
  import gmwf_tb_pkg::*;

  localparam int GRID = 16;

  logic       maze [GRID][GRID];
  logic [3:0] cur_row;
  logic [3:0] cur_col;
  logic [1:0] cur_heading;
  logic       heading_known;

  logic [3:0] cfg_start_row;
  logic [3:0] cfg_start_col;
  logic [1:0] cfg_start_heading;
  logic [3:0] cfg_goal_row;
  logic [3:0] cfg_goal_col;

  result_t expected_status_q [$];
  result_t want;
  int      mismatch_count;

  function automatic int row_delta(input logic [1:0] h);
    int d;
    case (h)
      DIR_UP:   d = -1;
      DIR_DOWN: d = 1;
      default:  d = 0;
    endcase
    return d;
  endfunction

  function automatic int col_delta(input logic [1:0] h);
    int d;
    case (h)
      DIR_LEFT:  d = -1;
      DIR_RIGHT: d = 1;
      default:   d = 0;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] right_of(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      DIR_UP:   r = DIR_RIGHT;
      DIR_DOWN: r = DIR_LEFT;
      DIR_LEFT: r = DIR_UP;
      default:  r = DIR_DOWN;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] left_of(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      DIR_UP:   r = DIR_LEFT;
      DIR_DOWN: r = DIR_RIGHT;
      DIR_LEFT: r = DIR_DOWN;
      default:  r = DIR_UP;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] back_of(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      DIR_UP:   r = DIR_DOWN;
      DIR_DOWN: r = DIR_UP;
      DIR_LEFT: r = DIR_RIGHT;
      default:  r = DIR_LEFT;
    endcase
    return r;
  endfunction

  function automatic bit on_grid(input int r, input int c);
    return r >= 0 && r < GRID && c >= 0 && c < GRID;
  endfunction

  // off-map cells read as walls
  function automatic bit cell_open(input int r, input int c);
    if (!on_grid(r, c)) return 1'b0;
    return maze[r][c] == 1'b0;
  endfunction

  function automatic result_t advance_robot(input logic [1:0] kind, input logic [3:0] row,
                                            input logic [3:0] col, input logic wall);
    result_t    res;
    logic [1:0] h, rh, lh, bh;
    int         pr, pc, fr, fc, rr, rc, lr, lc, br, bc;
    bit         right_open, found, no_exit;
    no_exit = 1'b0;
    case (kind)
      REQ_WRITE: maze[row][col] = wall;
      REQ_STEP: begin
        pr = int'(cur_row);
        pc = int'(cur_col);
        if (heading_known) begin
          h  = cur_heading;
          rh = right_of(h);
          lh = left_of(h);
          bh = back_of(h);
          fr = pr + row_delta(h);
          fc = pc + col_delta(h);
          rr = pr + row_delta(rh);
          rc = pc + col_delta(rh);
          lr = pr + row_delta(lh);
          lc = pc + col_delta(lh);
          br = pr + row_delta(bh);
          bc = pc + col_delta(bh);
          right_open = cell_open(rr, rc);
          if (!right_open && cell_open(fr, fc)) begin
            cur_row = 4'(fr);
            cur_col = 4'(fc);
          end else if (right_open && on_grid(fr, fc)) begin
            cur_row = 4'(rr);
            cur_col = 4'(rc);
            cur_heading = rh;
          end else if (cell_open(lr, lc)) begin
            cur_row = 4'(lr);
            cur_col = 4'(lc);
            cur_heading = lh;
          end else begin
            // turn back; the back cell itself is not checked
            if (on_grid(br, bc)) begin
              cur_row = 4'(br);
              cur_col = 4'(bc);
            end
            cur_heading = bh;
          end
        end else begin
          found = 1'b0;
          for (int k = 0; k < 4; k++) begin
            h = cfg_start_heading + 2'(k);
            if (!found && cell_open(pr + row_delta(h), pc + col_delta(h))) begin
              found = 1'b1;
              cur_row = 4'(pr + row_delta(h));
              cur_col = 4'(pc + col_delta(h));
              cur_heading = h;
              heading_known = 1'b1;
            end
          end
          no_exit = !found;
        end
      end
      REQ_RESTART: begin
        cur_row = cfg_start_row;
        cur_col = cfg_start_col;
        cur_heading = DIR_UP;
        heading_known = 1'b0;
      end
      default: ;
    endcase
    res.pos_row     = cur_row;
    res.pos_col     = cur_col;
    res.heading     = cur_heading;
    res.heading_set = heading_known;
    res.at_goal     = (cur_row == cfg_goal_row) && (cur_col == cfg_goal_col);
    res.stuck       = no_exit;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID; r++)
        for (int c = 0; c < GRID; c++)
          maze[r][c] = 1'b0;
      cur_row = '0;
      cur_col = '0;
      cur_heading = DIR_UP;
      heading_known = 1'b0;
      cfg_start_row = '0;
      cfg_start_col = '0;
      cfg_start_heading = DIR_UP;
      cfg_goal_row = '0;
      cfg_goal_col = '0;
      expected_status_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: row %0d col %0d heading %0d", pos_row_o, pos_col_o,
                     heading_out_o);
        end else begin
          want = expected_status_q.pop_front();
          if (pos_row_o !== want.pos_row || pos_col_o !== want.pos_col ||
              heading_out_o !== want.heading || heading_set_o !== want.heading_set ||
              at_goal_o !== want.at_goal || stuck_o !== want.stuck) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp %0d %0d %0d %0b %0b %0b got %0d %0d %0d %0b %0b %0b",
                       want.pos_row, want.pos_col, want.heading, want.heading_set,
                       want.at_goal, want.stuck, pos_row_o, pos_col_o, heading_out_o,
                       heading_set_o, at_goal_o, stuck_o);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_START_ROW:     cfg_start_row = pwdata[3:0];
          REG_START_COL:     cfg_start_col = pwdata[3:0];
          REG_START_HEADING: cfg_start_heading = pwdata[1:0];
          REG_GOAL_ROW:      cfg_goal_row = pwdata[3:0];
          REG_GOAL_COL:      cfg_goal_col = pwdata[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        expected_status_q.push_back(advance_robot(req_type_i, cell_row_i, cell_col_i,
                                                  cell_wall_i));
    end
    mismatch_count_o <= mismatch_count;
    pending_o <= expected_status_q.size();
  end

endmodule

// File: tb/grid_maze_wall_follower_tb.sv
module grid_maze_wall_follower_tb;

  import gmwf_pkg::*;
  import gmwf_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 630;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = REQ_WRITE;
  logic [3:0]  cell_row_i = '0;
  logic [3:0]  cell_col_i = '0;
  logic        cell_wall_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  pos_row_o;
  logic [3:0]  pos_col_o;
  logic [1:0]  heading_out_o;
  logic        heading_set_o;
  logic        at_goal_o;
  logic        stuck_o;

  int mismatch_total;
  int pending_count;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  grid_maze_wall_follower u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .cell_row_i    (cell_row_i),
    .cell_col_i    (cell_col_i),
    .cell_wall_i   (cell_wall_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pos_row_o     (pos_row_o),
    .pos_col_o     (pos_col_o),
    .heading_out_o (heading_out_o),
    .heading_set_o (heading_set_o),
    .at_goal_o     (at_goal_o),
    .stuck_o       (stuck_o)
  );

  grid_maze_wall_follower_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .cell_row_i       (cell_row_i),
    .cell_col_i       (cell_col_i),
    .cell_wall_i      (cell_wall_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pos_row_o        (pos_row_o),
    .pos_col_o        (pos_col_o),
    .heading_out_o    (heading_out_o),
    .heading_set_o    (heading_set_o),
    .at_goal_o        (at_goal_o),
    .stuck_o          (stuck_o),
    .mismatch_count_o (mismatch_total),
    .pending_o        (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // called and returns at a falling edge; valid stays up after acceptance
  task automatic send_item(input logic [1:0] kind, input logic [3:0] row,
                           input logic [3:0] col, input logic wall);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    cell_row_i  <= row;
    cell_col_i  <= col;
    cell_wall_i <= wall;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // leaves psel up between back-to-back writes
  task automatic apb_write(input cfg_reg_e idx, input logic [3:0] val);
    logic [31:0] wdata;
    wdata = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : 32'd0;
    wdata[3:0] = val;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  function automatic logic [3:0] pick_coord(input bit edge_only);
    if (edge_only || $urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? 4'd15 : 4'd0;
    return 4'($urandom_range(0, 15));
  endfunction

  // small walled room around the start, then a walk from a restart
  task automatic run_episode(input bit extreme);
    logic [3:0] srow, scol, grow, gcol;
    logic [1:0] shead;
    int         sz, r0, c0, density, nsteps;
    bit         enclose;
    srow = pick_coord(extreme);
    scol = pick_coord(extreme);
    shead = 2'($urandom_range(0, 3));
    sz = $urandom_range(2, 5);
    r0 = int'(srow) - $urandom_range(0, sz - 1);
    c0 = int'(scol) - $urandom_range(0, sz - 1);
    if (r0 < 0) r0 = 0;
    if (r0 > 16 - sz) r0 = 16 - sz;
    if (c0 < 0) c0 = 0;
    if (c0 > 16 - sz) c0 = 16 - sz;
    if (extreme) begin
      grow = pick_coord(1'b1);
      gcol = pick_coord(1'b1);
    end else if ($urandom_range(0, 7) == 0) begin
      grow = 4'($urandom_range(0, 15));
      gcol = 4'($urandom_range(0, 15));
    end else begin
      grow = 4'(r0 + $urandom_range(0, sz - 1));
      gcol = 4'(c0 + $urandom_range(0, sz - 1));
    end
    density = $urandom_range(10, 45);
    nsteps = $urandom_range(15, 45);
    enclose = ($urandom_range(0, 5) == 0);

    wait_drained();
    apb_write(REG_START_ROW, srow);
    apb_write(REG_START_COL, scol);
    apb_write(REG_START_HEADING, {2'b00, shead});
    apb_write(REG_GOAL_ROW, grow);
    apb_write(REG_GOAL_COL, gcol);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;

    for (int r = r0; r < r0 + sz; r++)
      for (int c = c0; c < c0 + sz; c++)
        send_item(REQ_WRITE, 4'(r), 4'(c),
                  (r == int'(srow) && c == int'(scol)) ? 1'b0
                  : ($urandom_range(0, 99) < density));
    for (int r = r0 - 1; r <= r0 + sz; r++)
      for (int c = c0 - 1; c <= c0 + sz; c++)
        if ((r == r0 - 1 || r == r0 + sz || c == c0 - 1 || c == c0 + sz) &&
            r >= 0 && r < 16 && c >= 0 && c < 16 && $urandom_range(0, 9) != 0)
          send_item(REQ_WRITE, 4'(r), 4'(c), 1'b1);
    if (enclose) begin
      if (srow > 4'd0)  send_item(REQ_WRITE, srow - 4'd1, scol, 1'b1);
      if (srow < 4'd15) send_item(REQ_WRITE, srow + 4'd1, scol, 1'b1);
      if (scol > 4'd0)  send_item(REQ_WRITE, srow, scol - 4'd1, 1'b1);
      if (scol < 4'd15) send_item(REQ_WRITE, srow, scol + 4'd1, 1'b1);
    end
    send_item(REQ_RESTART, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)));
    for (int i = 0; i < nsteps; i++) begin
      if (enclose && i == 2)
        send_item(REQ_WRITE, (srow < 4'd15) ? srow + 4'd1 : srow - 4'd1, scol, 1'b0);
      else if ($urandom_range(0, 99) < 12)
        send_noise();
      else
        send_item(REQ_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config: start and goal at the origin, first try up
    send_item(REQ_UNUSED, 4'd15, 4'd15, 1'b1);
    send_item(REQ_WRITE, 4'd0, 4'd1, 1'b1);
    send_item(REQ_WRITE, 4'd1, 4'd0, 1'b1);
    send_item(REQ_RESTART, 4'd0, 4'd0, 1'b0);
    send_item(REQ_STEP, 4'd0, 4'd0, 1'b0);
    send_item(REQ_STEP, 4'd15, 4'd15, 1'b1);
    send_item(REQ_WRITE, 4'd1, 4'd0, 1'b0);
    repeat (10) send_item(REQ_STEP, 4'd0, 4'd0, 1'b0);
    send_item(REQ_WRITE, 4'd15, 4'd15, 1'b1);
    send_item(REQ_WRITE, 4'd15, 4'd15, 1'b0);
    send_item(REQ_UNUSED, 4'd0, 4'd0, 1'b0);
    send_item(REQ_RESTART, 4'd15, 4'd15, 1'b1);
    send_item(REQ_STEP, 4'd0, 4'd0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_stall_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      run_episode(1'b1);
      while (items_sent < (phase + 1) * PHASE_ITEMS) run_episode(1'b0);
    end

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
